/* src/timed_event_queue_assert.svh */
// assertion macros for the timed event queue
// used by the top level; expects clk and arst_n in scope
`ifndef TIMED_EVENT_QUEUE_ASSERT_SVH
`define TIMED_EVENT_QUEUE_ASSERT_SVH

// same-cycle implication
`define TEQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define TEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* src/teq_pkg.sv */
// shared types and codes for the timed event queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package teq_pkg;
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 4;
	localparam int SEQ_W    = 48;
	localparam int DUE_W    = 48;
	localparam int URG_W    = 32;
	localparam int TYPE_FW  = 16;
	localparam int TGT_FW   = 16;
	localparam int DATA_FW  = 32;

	localparam logic [CMD_W-1:0] CMD_SCHEDULE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CANCEL   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TARGET   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READY    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

	localparam logic [STATUS_W-1:0] STS_SCHEDULED  = 4'd0;
	localparam logic [STATUS_W-1:0] STS_INVALID    = 4'd1;
	localparam logic [STATUS_W-1:0] STS_EXHAUSTED  = 4'd2;
	localparam logic [STATUS_W-1:0] STS_FULL       = 4'd3;
	localparam logic [STATUS_W-1:0] STS_CANCELLED  = 4'd4;
	localparam logic [STATUS_W-1:0] STS_NOT_FOUND  = 4'd5;
	localparam logic [STATUS_W-1:0] STS_READY      = 4'd6;
	localparam logic [STATUS_W-1:0] STS_NONE_READY = 4'd7;
	localparam logic [STATUS_W-1:0] STS_REMOVED    = 4'd8;
	localparam logic [STATUS_W-1:0] STS_NO_MATCH   = 4'd9;
	localparam logic [STATUS_W-1:0] STS_CLEARED    = 4'd10;

	localparam logic [SEQ_W-1:0] SEQ_FIRST = 48'd1;
	localparam logic [SEQ_W-1:0] SEQ_LAST  = {SEQ_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_EV,
		ST_PUT,
		ST_FIN
	} teq_state_t;
endpackage
`default_nettype wire

/* src/teq_ram.sv */
// generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module teq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* src/timed_event_queue.sv */
// channel | dir | tdata                                  | tuser   | tlast
// s_      | in  | type,target,due,urgency,data,cseq,now  | command | -
// m_      | out | seq,type,target,due,urgency,data       | status  | last
// one transaction at a time; clear, rejects and empty-table sweeps go straight to the final state
// schedule: walks back from the table end, moving up each entry that the new one precedes, then writes it in
// cancel, cancel-by-target and take-ready sweep all entries, each one read and then evaluated
// the sweep rate is set by the single entry memory, read then written back
// a full output register stalls the sweep when a second match must go out; reset empties the table at once
// depends on teq_pkg, teq_ram and timed_event_queue_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "timed_event_queue_assert.svh"
module timed_event_queue #(
	parameter int DEPTH        = 16,
	parameter int DATA_WIDTH   = 32,
	parameter int TYPE_WIDTH   = 16,
	parameter int TARGET_WIDTH = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// type, target, due_at, urgency, event_data, cancel_seq, now_tick
	input  wire logic [239:0]                 s_tdata,
	// command
	input  wire logic [teq_pkg::CMD_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// seq, type, target, due, urgency, data
	output logic      [191:0]                 m_tdata,
	// status
	output logic      [teq_pkg::STATUS_W-1:0] m_tuser,
	output logic                              m_tlast
);
	import teq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef struct packed {
		logic [SEQ_W-1:0]        seq;
		logic [TYPE_WIDTH-1:0]   typ;
		logic [TARGET_WIDTH-1:0] tgt;
		logic [DUE_W-1:0]        due;
		logic [URG_W-1:0]        urg;
		logic [DATA_WIDTH-1:0]   dat;
	} entry_t;

	teq_state_t state_q, state_d;

	logic [CMD_W-1:0]        cmd_q;
	entry_t                  new_q;
	logic [SEQ_W-1:0]        cseq_q;
	logic [DUE_W-1:0]        now_q;
	logic [STATUS_W-1:0]     res_status_q;
	logic [SEQ_W-1:0]        res_seq_q;
	logic [CW-1:0]           count_q;
	logic [SEQ_W-1:0]        next_seq_q;
	logic [AW-1:0]           r_q;
	logic [CW-1:0]           w_q;
	logic                    prefix_q;
	logic                    pend_v_q;
	logic [STATUS_W-1:0]     pend_status_q;
	entry_t                  pend_q;
	logic                    out_v_q;
	logic [STATUS_W-1:0]     out_status_q;
	entry_t                  out_q;
	logic                    out_last_q;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	entry_t                  ram_wdata;
	entry_t                  ram_rdata;

	logic [TYPE_WIDTH-1:0]   in_typ;
	logic [TARGET_WIDTH-1:0] in_tgt;
	logic [DUE_W-1:0]        in_due;
	logic [DATA_WIDTH-1:0]   in_dat;
	logic                    accept;
	logic                    ofree;
	logic                    is_insert;
	logic                    precede;
	logic                    match;
	logic                    stall;
	logic                    at_end;
	logic                    sched_ok;
	logic                    out_load;
	logic [STATUS_W-1:0]     match_status;

	teq_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(r_q),
		.rdata(ram_rdata)
	);

	assign in_typ = TYPE_WIDTH'(s_tdata[15:0]);
	assign in_tgt = TARGET_WIDTH'(s_tdata[31:16]);
	assign in_due = s_tdata[79:32];
	assign in_dat = DATA_WIDTH'(s_tdata[143:112]);

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign ofree     = !out_v_q || m_tready;
	assign is_insert = (cmd_q == CMD_SCHEDULE);
	assign at_end    = ((CW'(r_q) + CW'(1)) == count_q);
	assign sched_ok  = in_typ != '0 && in_due != '0 && next_seq_q != SEQ_LAST
		&& count_q != CW'(DEPTH);

	always_comb begin
		if (new_q.due != ram_rdata.due) begin
			precede = (new_q.due < ram_rdata.due);
		end else begin
			precede = ($signed(new_q.urg) < $signed(ram_rdata.urg));
		end
	end

	always_comb begin
		match        = 1'b0;
		match_status = STS_CANCELLED;
		case (cmd_q)
			CMD_CANCEL: begin
				match = !pend_v_q && (ram_rdata.seq == cseq_q);
			end
			CMD_TARGET: begin
				match        = (new_q.tgt != '0) && (ram_rdata.tgt == new_q.tgt);
				match_status = STS_REMOVED;
			end
			CMD_READY: begin
				match        = prefix_q && (ram_rdata.due <= now_q);
				match_status = STS_READY;
			end
			default: begin
				match = 1'b0;
			end
		endcase
	end

	assign stall = !is_insert && match && pend_v_q && !ofree;

	assign out_load = (state_q == ST_EV && !is_insert && !stall && match && pend_v_q)
		|| (state_q == ST_FIN && ofree);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_FIN;
					case (s_tuser)
						CMD_SCHEDULE: begin
							if (sched_ok) begin
								state_d = (count_q == '0) ? ST_PUT : ST_RD;
							end
						end
						CMD_CANCEL, CMD_TARGET, CMD_READY: begin
							state_d = (count_q == '0) ? ST_FIN : ST_RD;
						end
						default: begin
							state_d = ST_FIN;
						end
					endcase
				end
			end
			ST_RD: begin
				state_d = ST_EV;
			end
			ST_EV: begin
				if (is_insert) begin
					if (!precede) begin
						state_d = ST_FIN;
					end else if (r_q == '0) begin
						state_d = ST_PUT;
					end else begin
						state_d = ST_RD;
					end
				end else if (!stall) begin
					state_d = at_end ? ST_FIN : ST_RD;
				end
			end
			ST_PUT: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (ofree) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory writes
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = ram_rdata;
		case (state_q)
			ST_EV: begin
				if (is_insert) begin
					ram_we    = 1'b1;
					ram_waddr = r_q + AW'(1);
					ram_wdata = precede ? ram_rdata : new_q;
				end else if (!match) begin
					ram_we    = 1'b1;
					ram_waddr = w_q[AW-1:0];
				end
			end
			ST_PUT: begin
				ram_we    = 1'b1;
				ram_wdata = new_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			next_seq_q <= SEQ_FIRST;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			prefix_q   <= 1'b0;
			r_q        <= '0;
			w_q        <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pend_v_q <= 1'b0;
						prefix_q <= 1'b1;
						w_q      <= '0;
						if (s_tuser == CMD_SCHEDULE) begin
							r_q <= AW'(count_q - CW'(1));
						end else begin
							r_q <= '0;
						end
					end
				end
				ST_EV: begin
					if (is_insert) begin
						r_q <= r_q - AW'(1);
					end else if (!stall) begin
						if (!at_end) begin
							r_q <= r_q + AW'(1);
						end
						if (cmd_q == CMD_READY && !match) begin
							prefix_q <= 1'b0;
						end
						if (match) begin
							pend_v_q <= 1'b1;
						end else begin
							w_q <= w_q + CW'(1);
						end
					end
				end
				ST_FIN: begin
					if (ofree) begin
						case (cmd_q)
							CMD_SCHEDULE: begin
								if (res_status_q == STS_SCHEDULED) begin
									count_q    <= count_q + CW'(1);
									next_seq_q <= next_seq_q + SEQ_W'(1);
								end
							end
							CMD_CANCEL, CMD_TARGET, CMD_READY: begin
								count_q <= w_q;
							end
							CMD_CLEAR: begin
								count_q    <= '0;
								next_seq_q <= SEQ_FIRST;
							end
							default: begin
								count_q <= count_q;
							end
						endcase
					end
				end
				default: begin
					r_q <= r_q;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= s_tuser;
			new_q.seq <= next_seq_q;
			new_q.typ <= in_typ;
			new_q.tgt <= in_tgt;
			new_q.due <= in_due;
			new_q.urg <= s_tdata[111:80];
			new_q.dat <= in_dat;
			cseq_q    <= s_tdata[191:144];
			now_q     <= s_tdata[239:192];
			res_seq_q <= (s_tuser == CMD_SCHEDULE && sched_ok) ? next_seq_q : '0;
			case (s_tuser)
				CMD_SCHEDULE: begin
					if (in_typ == '0 || in_due == '0) begin
						res_status_q <= STS_INVALID;
					end else if (next_seq_q == SEQ_LAST) begin
						res_status_q <= STS_EXHAUSTED;
					end else if (count_q == CW'(DEPTH)) begin
						res_status_q <= STS_FULL;
					end else begin
						res_status_q <= STS_SCHEDULED;
					end
				end
				CMD_CANCEL: res_status_q <= STS_NOT_FOUND;
				CMD_TARGET: res_status_q <= STS_NO_MATCH;
				CMD_READY:  res_status_q <= STS_NONE_READY;
				CMD_CLEAR:  res_status_q <= STS_CLEARED;
				default:    res_status_q <= STS_INVALID;
			endcase
		end
		if (state_q == ST_EV && !is_insert && !stall && match) begin
			pend_q        <= ram_rdata;
			pend_status_q <= match_status;
			if (pend_v_q) begin
				out_q        <= pend_q;
				out_status_q <= pend_status_q;
				out_last_q   <= 1'b0;
			end
		end
		if (state_q == ST_FIN && ofree) begin
			out_last_q <= 1'b1;
			if (pend_v_q) begin
				out_q        <= pend_q;
				out_status_q <= pend_status_q;
			end else begin
				out_q        <= entry_t'({res_seq_q, {($bits(entry_t) - SEQ_W){1'b0}}});
				out_status_q <= res_status_q;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {DATA_FW'(out_q.dat), out_q.urg, out_q.due, TGT_FW'(out_q.tgt),
		TYPE_FW'(out_q.typ), out_q.seq};

	`TEQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "entry count above depth")
	`TEQ_ASSERT_NOW(a_compact_behind, state_q == ST_EV && !is_insert, w_q <= CW'(r_q), "compaction ahead of read")
	`TEQ_ASSERT_NEXT(a_busy_after_accept, accept, state_q != ST_IDLE, "idle right after accept")
	`TEQ_ASSERT_NOW(a_no_clobber, state_q == ST_EV && !is_insert && match && pend_v_q && out_v_q && !m_tready, ram_we == 1'b0, "write during stalled sweep")
endmodule
`default_nettype wire
